FILE: src/pmb_pkg.sv
// Peak meter ballistics: shared package.
// Holds field widths, register indexes, reset values and the config/flag structs.
// No dependencies.
package pmb_pkg;

  localparam int FIELD_W        = 16;
  localparam int LEVEL_BITS_DEF = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int HOLD_W         = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DECAY       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 3'd5;

  localparam logic               RST_STEREO_MODE      = 1'b0;
  localparam logic [FIELD_W-1:0] RST_ATTACK_COEFF     = 16'd52429;
  localparam logic [FIELD_W-1:0] RST_GRAVITY_STEP     = 16'd131;
  localparam logic [HOLD_W-1:0]  RST_HOLD_TICKS       = 8'd120;
  localparam logic [FIELD_W-1:0] RST_PEAK_DECAY       = 16'd62259;
  localparam logic [FIELD_W-1:0] RST_CHANGE_THRESHOLD = 16'd66;

  typedef struct packed {
    logic               stereo_mode;
    logic [FIELD_W-1:0] attack_coeff;
    logic [FIELD_W-1:0] gravity_step;
    logic [HOLD_W-1:0]  hold_ticks;
    logic [FIELD_W-1:0] peak_decay;
    logic [FIELD_W-1:0] change_threshold;
  } cfg_t;

  typedef struct packed {
    logic changed;
    logic active;
  } flags_t;

endpackage

FILE: src/pmb_chan.sv
// Peak meter ballistics: one channel's level, velocity, peak and hold state.
// Computes the next state combinationally and updates it when enabled.
// Depends on pmb_pkg.
module pmb_chan #(
  parameter int LEVEL_BITS = pmb_pkg::LEVEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  logic [pmb_pkg::FIELD_W-1:0] target,
  input  pmb_pkg::cfg_t               cfg,
  output logic [pmb_pkg::FIELD_W-1:0] level_o,
  output logic [pmb_pkg::FIELD_W-1:0] peak_o,
  output pmb_pkg::flags_t             flags
);
  import pmb_pkg::*;

  localparam int L  = LEVEL_BITS;
  localparam int PW = L + 16;
  localparam int SW = L + 18;

  logic [L-1:0]      level_r, level_nxt;
  logic [L-1:0]      peak_r, peak_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic [L:0]        vel_r, vel_nxt;

  logic [PW-1:0] tgt_w;
  logic [L-1:0]  tgt;
  logic          rise;
  logic [L-1:0]  gap;
  logic [PW-1:0] att_prod;
  logic [PW:0]   att_rnd;
  logic [L:0]    step;
  logic [SW-1:0] vsum;
  logic [L:0]    vel_max;
  logic [L:0]    v_sat;
  logic [L:0]    lvl_w;
  logic [L:0]    fall_w;
  logic [PW-1:0] dec_prod;
  logic [L-1:0]  diff;
  logic [PW-1:0] thr_w;
  logic [PW-1:0] lvl_out_w;
  logic [PW-1:0] pk_out_w;

  always_comb begin
    tgt_w    = PW'(target);
    tgt      = tgt_w[L-1:0];
    rise     = tgt > level_r;
    gap      = tgt - level_r;
    att_prod = PW'(gap) * PW'(cfg.attack_coeff);
    att_rnd  = {1'b0, att_prod} + (PW+1)'(32768);
    step     = att_rnd[PW:16];
    vsum     = SW'(vel_r) + SW'(cfg.gravity_step);
    vel_max  = '1;
    v_sat    = (vsum > SW'(vel_max)) ? vel_max : vsum[L:0];
    lvl_w    = {1'b0, level_r};
    fall_w   = (v_sat >= lvl_w) ? '0 : (lvl_w - v_sat);
    dec_prod = PW'(peak_r) * PW'(cfg.peak_decay);

    if (rise) begin
      level_nxt = level_r + step[L-1:0];
      vel_nxt   = '0;
    end else if (fall_w[L-1:0] < tgt) begin
      level_nxt = tgt;
      vel_nxt   = '0;
    end else begin
      level_nxt = fall_w[L-1:0];
      vel_nxt   = v_sat;
    end

    if (level_nxt > peak_r) begin
      peak_nxt = level_nxt;
      hold_nxt = cfg.hold_ticks;
    end else if (hold_r != '0) begin
      peak_nxt = peak_r;
      hold_nxt = hold_r - 1'b1;
    end else begin
      peak_nxt = dec_prod[PW-1:16];
      hold_nxt = hold_r;
    end

    diff          = (level_nxt > level_r) ? (level_nxt - level_r) : (level_r - level_nxt);
    thr_w         = PW'(cfg.change_threshold);
    flags.changed = PW'(diff) > thr_w;
    flags.active  = (PW'(level_nxt) > thr_w) || (PW'(peak_nxt) > thr_w);
    lvl_out_w     = PW'(level_nxt);
    pk_out_w      = PW'(peak_nxt);
    level_o       = lvl_out_w[FIELD_W-1:0];
    peak_o        = pk_out_w[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      peak_r  <= '0;
      hold_r  <= '0;
      vel_r   <= '0;
    end else if (upd) begin
      level_r <= level_nxt;
      peak_r  <= peak_nxt;
      hold_r  <= hold_nxt;
      vel_r   <= vel_nxt;
    end
  end

  a_rise_clears_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && rise) |=> (vel_r == '0))
    else $error("fall velocity not cleared after rise");

  a_hold_keeps_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && (hold_r != '0) && !(level_nxt > peak_r)) |=> (peak_r == $past(peak_r)))
    else $error("peak moved during hold");

  a_peak_tracks_level: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && (level_nxt > peak_r)) |=> (peak_r == level_r))
    else $error("peak not captured from level");

endmodule

FILE: src/peak_meter_ballistics_top.sv
// Peak meter ballistics with peak hold: top level.
// Each item passes through the input register, then the result register.
// One item per cycle when out_stall is low; channel state updates in one pass per item.
// Reset (rst_n low, synchronous): levels, peaks, hold counts and velocities clear,
// config registers return to defaults, both channels empty.
// Depends on pmb_pkg and pmb_chan.
module peak_meter_ballistics_top #(
  parameter int LEVEL_BITS = pmb_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pmb_pkg::FIELD_W-1:0]   in_target_left,
  input  logic [pmb_pkg::FIELD_W-1:0]   in_target_right,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pmb_pkg::FIELD_W-1:0]   out_level_left,
  output logic [pmb_pkg::FIELD_W-1:0]   out_level_right,
  output logic [pmb_pkg::FIELD_W-1:0]   out_peak_left,
  output logic [pmb_pkg::FIELD_W-1:0]   out_peak_right,
  output logic                          out_changed,
  output logic                          out_active,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmb_pkg::FIELD_W-1:0]   cfg_data
);
  import pmb_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  logic [FIELD_W-1:0] tl_r, tr_r;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] lvl_l_r, lvl_r_r, pk_l_r, pk_r_r;
  logic               changed_r, active_r;

  logic               advance, s1_fire, in_xfer;
  logic [FIELD_W-1:0] lvl_l, lvl_rt, pk_l, pk_rt;
  flags_t             fl_l, fl_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEREO_MODE:      cfg_nxt.stereo_mode      = cfg_data[0];
        CFG_ATTACK_COEFF:     cfg_nxt.attack_coeff     = cfg_data;
        CFG_GRAVITY_STEP:     cfg_nxt.gravity_step     = cfg_data;
        CFG_HOLD_TICKS:       cfg_nxt.hold_ticks       = cfg_data[HOLD_W-1:0];
        CFG_PEAK_DECAY:       cfg_nxt.peak_decay       = cfg_data;
        CFG_CHANGE_THRESHOLD: cfg_nxt.change_threshold = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stereo_mode      <= RST_STEREO_MODE;
      cfg_r.attack_coeff     <= RST_ATTACK_COEFF;
      cfg_r.gravity_step     <= RST_GRAVITY_STEP;
      cfg_r.hold_ticks       <= RST_HOLD_TICKS;
      cfg_r.peak_decay       <= RST_PEAK_DECAY;
      cfg_r.change_threshold <= RST_CHANGE_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_fire);
    out_valid_nxt = s1_fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tl_r <= in_target_left;
      tr_r <= in_target_right;
    end
  end

  pmb_chan #(.LEVEL_BITS(LEVEL_BITS)) u_chan_l (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (s1_fire),
    .target  (tl_r),
    .cfg     (cfg_r),
    .level_o (lvl_l),
    .peak_o  (pk_l),
    .flags   (fl_l)
  );

  pmb_chan #(.LEVEL_BITS(LEVEL_BITS)) u_chan_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (s1_fire && cfg_r.stereo_mode),
    .target  (tr_r),
    .cfg     (cfg_r),
    .level_o (lvl_rt),
    .peak_o  (pk_rt),
    .flags   (fl_r)
  );

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      lvl_l_r   <= lvl_l;
      pk_l_r    <= pk_l;
      lvl_r_r   <= cfg_r.stereo_mode ? lvl_rt : '0;
      pk_r_r    <= cfg_r.stereo_mode ? pk_rt : '0;
      changed_r <= fl_l.changed || (cfg_r.stereo_mode && fl_r.changed);
      active_r  <= fl_l.active || (cfg_r.stereo_mode && fl_r.active);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_level_left  = lvl_l_r;
  assign out_level_right = lvl_r_r;
  assign out_peak_left   = pk_l_r;
  assign out_peak_right  = pk_r_r;
  assign out_changed     = changed_r;
  assign out_active      = active_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result register not loaded after transfer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !s1_fire)
    else $error("waiting result overwritten");

endmodule
